// ===== src/tcc_pkg.sv =====
// ---------------------------------------------------------------------------
// Triangle circumcircle package
// Widths of the arithmetic datapath and output saturation bounds.
// ---------------------------------------------------------------------------
package tcc_pkg;

   localparam int COORD_W  = 16;              // Q8.8 vertex coordinate
   localparam int REQ_W    = 6 * COORD_W;     // packed request data
   localparam int RSP_W    = 96;              // packed result data
   localparam int AMAG_W   = 34;              // magnitude of the determinant
   localparam int NUM_W    = 57;              // magnitude of a centre numerator
   localparam int CDIV_QW  = 33;              // centre quotient bits
   localparam int CDIV_RW  = AMAG_W + CDIV_QW; // centre divider remainder
   localparam int SQ_XW    = 116;             // radicand width
   localparam int ROOT_W   = 58;              // integer square root width
   localparam int RDIV_QW  = 32;              // radius quotient bits
   localparam int RDIV_RW  = AMAG_W + RDIV_QW; // radius divider remainder

   localparam logic [31:0] CENTER_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] CENTER_MIN = 32'h8000_0000;
   localparam logic [31:0] RADIUS_MAX = 32'hFFFF_FFFF;

endpackage

// ===== src/tcc_div_cell.sv =====
// ---------------------------------------------------------------------------
// Divider cell
// One restoring division step: produces quotient bit BIT and passes the
// partial remainder, divisor and quotient on to the next cell.
// ---------------------------------------------------------------------------
module tcc_div_cell #(
   parameter int RW  = tcc_pkg::CDIV_RW,
   parameter int DW  = tcc_pkg::AMAG_W,
   parameter int QW  = tcc_pkg::CDIV_QW,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [RW-1:0] up_rem,
   input  logic [DW-1:0] up_den,
   input  logic [QW-1:0] up_quo,
   output logic [RW-1:0] dn_rem,
   output logic [DW-1:0] dn_den,
   output logic [QW-1:0] dn_quo
);
   import tcc_pkg::*;

   logic [RW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] quo_ff, quo_in;
   logic [RW-1:0] shifted;
   logic          take;

   always_comb begin
      shifted = RW'(up_den) << BIT;
      take    = (up_rem >= shifted);
      rem_in  = take ? (up_rem - shifted) : up_rem;
      quo_in  = up_quo | (QW'(take) << BIT);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         den_ff <= up_den;
         quo_ff <= quo_in;
      end
   end

   assign dn_rem = rem_ff;
   assign dn_den = den_ff;
   assign dn_quo = quo_ff;

endmodule

// ===== src/tcc_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// Square root cell
// One digit-by-digit step of the integer square root: decides root bit BIT
// and passes the remainder and the partial root to the next cell.
// ---------------------------------------------------------------------------
module tcc_sqrt_cell #(
   parameter int XW  = tcc_pkg::SQ_XW,
   parameter int TW  = tcc_pkg::ROOT_W,
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [XW-1:0] up_rem,
   input  logic [TW-1:0] up_root,
   output logic [XW-1:0] dn_rem,
   output logic [TW-1:0] dn_root
);
   import tcc_pkg::*;

   logic [XW-1:0] rem_ff, rem_in;
   logic [TW-1:0] root_ff, root_in;
   logic [XW:0]   trial;
   logic          take;

   // (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
   always_comb begin
      trial   = ((XW+1)'(up_root) << (BIT + 1)) | ((XW+1)'(1) << (2 * BIT));
      take    = ({1'b0, up_rem} >= trial);
      rem_in  = take ? (up_rem - trial[XW-1:0]) : up_rem;
      root_in = up_root | (TW'(take) << BIT);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;

endmodule

// ===== src/triangle_circumcircle.sv =====
// ---------------------------------------------------------------------------
// Triangle circumcircle
// Streams triangles in and returns the circumcentre, circumradius and a
// collinearity flag for each, one item per clock unless the output stalls.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   req_*     in         tdata: p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (Q8.8)
//   rsp_*     out        tdata: center_x, center_y, radius (Q16.16)
//                        tuser: degenerate
//
// One item enters per cycle while the chain moves. The chain has 98 register
// stages: 7 arithmetic stages, 58 square root cells, 32 radius divider cells
// and the result register. The centre dividers (33 cells) run beside the
// square root. Reset clears only the valid bits of the stages. When the
// result register holds an item that is not taken, the whole chain holds,
// and req_tready follows the state of that register.
// ---------------------------------------------------------------------------
module triangle_circumcircle (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, 16 bits each from the lowest bit up
   input  logic [tcc_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // center_x, center_y, radius, 32 bits each from the lowest bit up
   output logic [tcc_pkg::RSP_W-1:0] rsp_tdata,
   // degenerate
   output logic                      rsp_tuser
);
   import tcc_pkg::*;

   localparam int LAST = 98;

   // Floor quotient with saturation to the signed 32-bit range.
   function automatic logic [31:0] center_sat(input logic [CDIV_QW-1:0] quo,
                                              input logic rnz, input logic neg,
                                              input logic ovf);
      logic [CDIV_QW:0] t;
      logic [CDIV_QW:0] t_neg;
      logic [31:0]      res;
      t     = (CDIV_QW+1)'(quo) + (CDIV_QW+1)'(rnz);
      t_neg = -t;
      if (ovf)
         res = neg ? CENTER_MIN : CENTER_MAX;
      else if (!neg)
         res = (quo > CDIV_QW'(CENTER_MAX)) ? CENTER_MAX : quo[31:0];
      else
         res = (t > (CDIV_QW+1)'(CENTER_MIN)) ? CENTER_MIN : t_neg[31:0];
      return res;
   endfunction

   logic adv;
   logic vld_ff [1:LAST];

   assign adv        = !vld_ff[LAST] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= LAST; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= req_tvalid;
         for (int s = 2; s <= LAST; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   // Unpack the vertices.
   logic signed [15:0] x1, y1, x2, y2, x3, y3;
   assign x1 = req_tdata[15:0];
   assign y1 = req_tdata[31:16];
   assign x2 = req_tdata[47:32];
   assign y2 = req_tdata[63:48];
   assign x3 = req_tdata[79:64];
   assign y3 = req_tdata[95:80];

   // Stage 1: differences and coordinate squares.
   logic signed [16:0] dx2_1_ff, dy2_1_ff, dx3_1_ff, dy3_1_ff;
   logic signed [16:0] yd23_ff, yd31_ff, yd12_ff, xd23_ff, xd31_ff, xd12_ff;
   logic [30:0]        sqx1_ff, sqy1_ff, sqx2_ff, sqy2_ff, sqx3_ff, sqy3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dx2_1_ff <= 17'(x2) - 17'(x1);
         dy2_1_ff <= 17'(y2) - 17'(y1);
         dx3_1_ff <= 17'(x3) - 17'(x1);
         dy3_1_ff <= 17'(y3) - 17'(y1);
         yd23_ff  <= 17'(y2) - 17'(y3);
         yd31_ff  <= 17'(y3) - 17'(y1);
         yd12_ff  <= 17'(y1) - 17'(y2);
         xd23_ff  <= 17'(x2) - 17'(x3);
         xd31_ff  <= 17'(x3) - 17'(x1);
         xd12_ff  <= 17'(x1) - 17'(x2);
         sqx1_ff  <= 31'(32'(x1) * 32'(x1));
         sqy1_ff  <= 31'(32'(y1) * 32'(y1));
         sqx2_ff  <= 31'(32'(x2) * 32'(x2));
         sqy2_ff  <= 31'(32'(y2) * 32'(y2));
         sqx3_ff  <= 31'(32'(x3) * 32'(x3));
         sqy3_ff  <= 31'(32'(y3) * 32'(y3));
      end
   end

   // Stage 2: determinant products, squared edge terms, squared norms.
   logic signed [33:0] pa1_ff, pa2_ff;
   logic [32:0]        dx2sq_ff, dy2sq_ff, dx3sq_ff, dy3sq_ff;
   logic [31:0]        s1_ff, s2_ff, s3_ff;
   logic signed [16:0] dx2_2_ff, dy2_2_ff, dx3_2_ff, dy3_2_ff;
   logic signed [16:0] yd23_2_ff, yd31_2_ff, yd12_2_ff;
   logic signed [16:0] xd23_2_ff, xd31_2_ff, xd12_2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pa1_ff    <= 34'(dx2_1_ff) * 34'(dy3_1_ff);
         pa2_ff    <= 34'(dx3_1_ff) * 34'(dy2_1_ff);
         dx2sq_ff  <= 33'(34'(dx2_1_ff) * 34'(dx2_1_ff));
         dy2sq_ff  <= 33'(34'(dy2_1_ff) * 34'(dy2_1_ff));
         dx3sq_ff  <= 33'(34'(dx3_1_ff) * 34'(dx3_1_ff));
         dy3sq_ff  <= 33'(34'(dy3_1_ff) * 34'(dy3_1_ff));
         s1_ff     <= 32'(sqx1_ff) + 32'(sqy1_ff);
         s2_ff     <= 32'(sqx2_ff) + 32'(sqy2_ff);
         s3_ff     <= 32'(sqx3_ff) + 32'(sqy3_ff);
         dx2_2_ff  <= dx2_1_ff;
         dy2_2_ff  <= dy2_1_ff;
         dx3_2_ff  <= dx3_1_ff;
         dy3_2_ff  <= dy3_1_ff;
         yd23_2_ff <= yd23_ff;
         yd31_2_ff <= yd31_ff;
         yd12_2_ff <= yd12_ff;
         xd23_2_ff <= xd23_ff;
         xd31_2_ff <= xd31_ff;
         xd12_2_ff <= xd12_ff;
      end
   end

   // Stage 3: determinant, squared edge lengths, numerator products.
   logic signed [34:0] a3_ff;
   logic [33:0]        q2_ff, q3_ff;
   logic signed [47:0] t1_ff, t2_ff, t3_ff, u1_ff, u2_ff, u3_ff;
   logic signed [16:0] dx2_3_ff, dy2_3_ff, dx3_3_ff, dy3_3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a3_ff    <= 35'(pa1_ff) - 35'(pa2_ff);
         q2_ff    <= 34'(dx2sq_ff) + 34'(dy2sq_ff);
         q3_ff    <= 34'(dx3sq_ff) + 34'(dy3sq_ff);
         t1_ff    <= 48'($signed({1'b0, s1_ff})) * 48'(yd23_2_ff);
         t2_ff    <= 48'($signed({1'b0, s2_ff})) * 48'(yd31_2_ff);
         t3_ff    <= 48'($signed({1'b0, s3_ff})) * 48'(yd12_2_ff);
         u1_ff    <= 48'($signed({1'b0, s1_ff})) * 48'(xd23_2_ff);
         u2_ff    <= 48'($signed({1'b0, s2_ff})) * 48'(xd31_2_ff);
         u3_ff    <= 48'($signed({1'b0, s3_ff})) * 48'(xd12_2_ff);
         dx2_3_ff <= dx2_2_ff;
         dy2_3_ff <= dy2_2_ff;
         dx3_3_ff <= dx3_2_ff;
         dy3_3_ff <= dy3_2_ff;
      end
   end

   // Stage 4: centre numerator sums and the radius vector products.
   logic signed [49:0] sumx_ff, sumy_ff;
   logic signed [51:0] r1_ff, r2_ff, r3_ff, r4_ff;
   logic signed [34:0] a4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sumx_ff <= 50'(t1_ff) + 50'(t2_ff) + 50'(t3_ff);
         sumy_ff <= 50'(u1_ff) + 50'(u2_ff) + 50'(u3_ff);
         r1_ff   <= 52'($signed({1'b0, q2_ff})) * 52'(dy3_3_ff);
         r2_ff   <= 52'($signed({1'b0, q3_ff})) * 52'(dy2_3_ff);
         r3_ff   <= 52'($signed({1'b0, q3_ff})) * 52'(dx2_3_ff);
         r4_ff   <= 52'($signed({1'b0, q2_ff})) * 52'(dx3_3_ff);
         a4_ff   <= a3_ff;
      end
   end

   // Stage 5: magnitudes and quotient signs. The x numerator is sumx * 128
   // and the y numerator is -sumy * 128; the floor division works on
   // magnitudes with the sign of the true quotient kept aside.
   logic signed [51:0] ux_w, uy_w;
   logic [49:0]        smx_w, smy_w;
   logic [49:0]        umx_ff, umy_ff;
   logic [NUM_W-1:0]   nmx_ff, nmy_ff;
   logic               a_neg;

   logic [AMAG_W-1:0]  amag_d  [5:65];
   logic               degen_d [5:LAST-1];
   logic               negx_d  [5:38];
   logic               negy_d  [5:38];

   always_comb begin
      ux_w  = r1_ff - r2_ff;
      uy_w  = r3_ff - r4_ff;
      smx_w = sumx_ff[49] ? 50'(-sumx_ff) : 50'(sumx_ff);
      smy_w = sumy_ff[49] ? 50'(-sumy_ff) : 50'(sumy_ff);
      a_neg = a4_ff[34];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         umx_ff     <= ux_w[51] ? 50'(-ux_w) : 50'(ux_w);
         umy_ff     <= uy_w[51] ? 50'(-uy_w) : 50'(uy_w);
         nmx_ff     <= {smx_w, 7'b0};
         nmy_ff     <= {smy_w, 7'b0};
         negx_d[5]  <= (sumx_ff != '0) && (sumx_ff[49] ^ a_neg);
         negy_d[5]  <= (sumy_ff != '0) && (!sumy_ff[49] ^ a_neg);
         amag_d[5]  <= a_neg ? AMAG_W'(-a4_ff) : AMAG_W'(a4_ff);
         degen_d[5] <= (a4_ff == '0);
      end
   end

   // Stage 6: overflow checks for the centre quotients and the split
   // partial products for squaring the radius vector.
   logic        ovfx_d [6:38];
   logic        ovfy_d [6:38];
   logic [49:0] hhx_ff, hlx_ff, llx_ff, hhy_ff, hly_ff, lly_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ovfx_d[6] <= CDIV_RW'(nmx_ff) >= {amag_d[5], CDIV_QW'(0)};
         ovfy_d[6] <= CDIV_RW'(nmy_ff) >= {amag_d[5], CDIV_QW'(0)};
         hhx_ff    <= 50'(umx_ff[49:25]) * 50'(umx_ff[49:25]);
         hlx_ff    <= 50'(umx_ff[49:25]) * 50'(umx_ff[24:0]);
         llx_ff    <= 50'(umx_ff[24:0]) * 50'(umx_ff[24:0]);
         hhy_ff    <= 50'(umy_ff[49:25]) * 50'(umy_ff[49:25]);
         hly_ff    <= 50'(umy_ff[49:25]) * 50'(umy_ff[24:0]);
         lly_ff    <= 50'(umy_ff[24:0]) * 50'(umy_ff[24:0]);
      end
   end

   // Stage 7: radicand, the squared norm of the radius vector times 2^14.
   // The cross term counts twice, hence the shift of 40 rather than 39.
   logic [SQ_XW-1:0] m_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= (SQ_XW'(hhx_ff) << 64) + (SQ_XW'(hlx_ff) << 40) + (SQ_XW'(llx_ff) << 14)
               + (SQ_XW'(hhy_ff) << 64) + (SQ_XW'(hly_ff) << 40) + (SQ_XW'(lly_ff) << 14);
      end
   end

   // Centre dividers: 33 cells, fed from stage 5, last cell at stage 38.
   logic [CDIV_RW-1:0] cxr [0:CDIV_QW];
   logic [CDIV_RW-1:0] cyr [0:CDIV_QW];
   logic [AMAG_W-1:0]  cxd [0:CDIV_QW];
   logic [AMAG_W-1:0]  cyd [0:CDIV_QW];
   logic [CDIV_QW-1:0] cxq [0:CDIV_QW];
   logic [CDIV_QW-1:0] cyq [0:CDIV_QW];

   assign cxr[0] = CDIV_RW'(nmx_ff);
   assign cyr[0] = CDIV_RW'(nmy_ff);
   assign cxd[0] = amag_d[5];
   assign cyd[0] = amag_d[5];
   assign cxq[0] = '0;
   assign cyq[0] = '0;

   for (genvar c = 0; c < CDIV_QW; c++) begin : g_cdiv
      tcc_div_cell #(.RW(CDIV_RW), .DW(AMAG_W), .QW(CDIV_QW), .BIT(CDIV_QW - 1 - c))
         u_cx (.clock(clock), .adv(adv), .up_rem(cxr[c]), .up_den(cxd[c]), .up_quo(cxq[c]),
               .dn_rem(cxr[c+1]), .dn_den(cxd[c+1]), .dn_quo(cxq[c+1]));
      tcc_div_cell #(.RW(CDIV_RW), .DW(AMAG_W), .QW(CDIV_QW), .BIT(CDIV_QW - 1 - c))
         u_cy (.clock(clock), .adv(adv), .up_rem(cyr[c]), .up_den(cyd[c]), .up_quo(cyq[c]),
               .dn_rem(cyr[c+1]), .dn_den(cyd[c+1]), .dn_quo(cyq[c+1]));
   end

   // Stage 39: floor rounding and saturation of the centre.
   logic [31:0] cx_d [39:LAST-1];
   logic [31:0] cy_d [39:LAST-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_d[39] <= center_sat(cxq[CDIV_QW], cxr[CDIV_QW] != '0, negx_d[38], ovfx_d[38]);
         cy_d[39] <= center_sat(cyq[CDIV_QW], cyr[CDIV_QW] != '0, negy_d[38], ovfy_d[38]);
      end
   end

   // Square root: 58 cells, fed from stage 7, last cell at stage 65.
   logic [SQ_XW-1:0]  srem  [0:ROOT_W];
   logic [ROOT_W-1:0] sroot [0:ROOT_W];

   assign srem[0]  = m_ff;
   assign sroot[0] = '0;

   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      tcc_sqrt_cell #(.XW(SQ_XW), .TW(ROOT_W), .BIT(ROOT_W - 1 - j))
         u_sq (.clock(clock), .adv(adv), .up_rem(srem[j]), .up_root(sroot[j]),
               .dn_rem(srem[j+1]), .dn_root(sroot[j+1]));
   end

   // Radius divider: 32 cells, fed from stage 65, last cell at stage 97.
   logic [RDIV_RW-1:0] rr [0:RDIV_QW];
   logic [AMAG_W-1:0]  rd [0:RDIV_QW];
   logic [RDIV_QW-1:0] rq [0:RDIV_QW];
   logic               ovfr_d [66:LAST-1];

   assign rr[0] = RDIV_RW'(sroot[ROOT_W]);
   assign rd[0] = amag_d[65];
   assign rq[0] = '0;

   for (genvar j = 0; j < RDIV_QW; j++) begin : g_rdiv
      tcc_div_cell #(.RW(RDIV_RW), .DW(AMAG_W), .QW(RDIV_QW), .BIT(RDIV_QW - 1 - j))
         u_rd (.clock(clock), .adv(adv), .up_rem(rr[j]), .up_den(rd[j]), .up_quo(rq[j]),
               .dn_rem(rr[j+1]), .dn_den(rd[j+1]), .dn_quo(rq[j+1]));
   end

   // Side data traveling along the chain.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 6; s <= 65; s++) amag_d[s] <= amag_d[s-1];
         for (int s = 6; s <= LAST - 1; s++) degen_d[s] <= degen_d[s-1];
         for (int s = 6; s <= 38; s++) begin
            negx_d[s] <= negx_d[s-1];
            negy_d[s] <= negy_d[s-1];
         end
         for (int s = 7; s <= 38; s++) begin
            ovfx_d[s] <= ovfx_d[s-1];
            ovfy_d[s] <= ovfy_d[s-1];
         end
         for (int s = 40; s <= LAST - 1; s++) begin
            cx_d[s] <= cx_d[s-1];
            cy_d[s] <= cy_d[s-1];
         end
         ovfr_d[66] <= rr[0] >= {amag_d[65], RDIV_QW'(0)};
         for (int s = 67; s <= LAST - 1; s++) ovfr_d[s] <= ovfr_d[s-1];
      end
   end

   // Stage 98: result register. Collinear vertices give zero fields.
   logic [RSP_W-1:0] rsp_data_ff;
   logic             rsp_user_ff;
   logic [31:0]      rad_w;

   assign rad_w = ovfr_d[LAST-1] ? RADIUS_MAX : rq[RDIV_QW];

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_user_ff <= degen_d[LAST-1];
         rsp_data_ff <= degen_d[LAST-1] ? '0 : {rad_w, cy_d[LAST-1], cx_d[LAST-1]};
      end
   end

   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A collinear triangle reports all result fields as zero.
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate item with nonzero fields");

   // A waiting result holds the whole chain, so no item may enter.
   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item accepted while the result register is stalled");

   // With the result register empty the chain always moves.
   a_empty_moves : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("chain held with an empty result register");

endmodule

// ===== tb/tb_triangle_circumcircle.sv =====
// ---------------------------------------------------------------------------
// Triangle circumcircle testbench
// Streams directed and random triangles through the block, predicts the
// circumcentre, circumradius and collinearity flag of each, and checks every
// result item in order while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_triangle_circumcircle;
   timeunit 1ns;
   timeprecision 1ps;

   import tcc_pkg::*;

   typedef struct packed {
      logic [31:0] center_x;
      logic [31:0] center_y;
      logic [31:0] radius;
      logic        degenerate;
   } circle_type;

   localparam int LATENCY     = 98;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 700;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   // Floor division of the centre numerator, saturated to a 32-bit result.
   function automatic logic [31:0] centre_coord(input longint num, input longint den);
      longint q;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      q = num / den;
      if (num % den != 0 && num < 0) q--;
      if (q > 64'sd2147483647) return CENTER_MAX;
      if (q < -64'sd2147483648) return CENTER_MIN;
      return q[31:0];
   endfunction

   // Integer square root by bit trial over the full radicand width.
   function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [SQ_XW-1:0] x);
      logic [ROOT_W-1:0] r;
      logic [ROOT_W-1:0] c;
      r = '0;
      for (int k = ROOT_W - 1; k >= 0; k--) begin
         c = r | (58'd1 << k);
         if ({58'd0, c} * {58'd0, c} <= x) r = c;
      end
      return r;
   endfunction

   function automatic circle_type circumcircle(input logic [REQ_W-1:0] tri_bits);
      longint x1, y1, x2, y2, x3, y3, a, s1, s2, s3, bx, by;
      longint dx2, dy2, dx3, dy3, q2, q3, ux, uy, amag;
      logic [127:0] m, ax, ay;
      logic [ROOT_W-1:0] root;
      logic [63:0] rad;
      circle_type res;
      x1 = $signed(tri_bits[15:0]);  y1 = $signed(tri_bits[31:16]);
      x2 = $signed(tri_bits[47:32]); y2 = $signed(tri_bits[63:48]);
      x3 = $signed(tri_bits[79:64]); y3 = $signed(tri_bits[95:80]);
      res = '0;
      a = x1 * y2 + y1 * x3 + x2 * y3 - (x1 * y3 + y1 * x2 + y2 * x3);
      if (a == 0) begin
         res.degenerate = 1'b1;
         return res;
      end
      s1 = x1 * x1 + y1 * y1;
      s2 = x2 * x2 + y2 * y2;
      s3 = x3 * x3 + y3 * y3;
      bx = -(s1 * (y2 - y3) + s2 * (y3 - y1) + s3 * (y1 - y2));
      by = s1 * (x2 - x3) + s2 * (x3 - x1) + s3 * (x1 - x2);
      res.center_x = centre_coord(-bx * 128, a);
      res.center_y = centre_coord(-by * 128, a);
      dx2 = x2 - x1; dy2 = y2 - y1;
      dx3 = x3 - x1; dy3 = y3 - y1;
      q2 = dx2 * dx2 + dy2 * dy2;
      q3 = dx3 * dx3 + dy3 * dy3;
      ux = q2 * dy3 - q3 * dy2;
      uy = q3 * dx2 - q2 * dx3;
      ax = (ux < 0) ? -ux : ux;
      ay = (uy < 0) ? -uy : uy;
      m = (ax * ax + ay * ay) << 14;
      root = floor_sqrt(m[SQ_XW-1:0]);
      amag = (a < 0) ? -a : a;
      rad = {6'd0, root} / amag;
      res.radius = (rad > 64'hFFFF_FFFF) ? RADIUS_MAX : rad[31:0];
      return res;
   endfunction

   // Holds the circles still owed by the block, oldest first.
   class circle_scoreboard;
      circle_type pending[$];

      function void note_triangle(logic [REQ_W-1:0] tri_bits);
         pending.push_back(circumcircle(tri_bits));
      endfunction

      task check_circle(logic [RSP_W-1:0] data, logic flag);
         circle_type want;
         if (pending.size() == 0) begin
            $display("result item arrived with nothing expected");
            error_count++;
            return;
         end
         want = pending.pop_front();
         if (data[31:0] !== want.center_x)
            report_mismatch("center_x", data[31:0], want.center_x);
         if (data[63:32] !== want.center_y)
            report_mismatch("center_y", data[63:32], want.center_y);
         if (data[95:64] !== want.radius)
            report_mismatch("radius", data[95:64], want.radius);
         if (flag !== want.degenerate)
            report_mismatch("degenerate", {31'd0, flag}, {31'd0, want.degenerate});
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;

   circle_scoreboard board = new();
   int  cycle_count = 0;
   bit  long_hold = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   triangle_circumcircle u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // Every accepted triangle is predicted at the edge that takes it, and
   // every accepted result is checked at the edge that takes it.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_tvalid && req_tready) board.note_triangle(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_circle(rsp_tdata, rsp_tuser);
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("triangle_circumcircle test failed");
         $finish;
      end
   end

   // Receiver stall pattern: runs of ready and not ready of random length,
   // with a long hold-off when the stimulus asks for one.
   initial begin : receiver
      int run;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         run = $urandom_range(1, 12);
         rsp_tready <= ($urandom_range(0, 3) != 0);
         repeat (run) @(posedge clock);
      end
   end

   int burst_left = 0;

   // Offer one triangle and hold it until the block takes it. Bursts of
   // random length are separated by random gaps.
   task automatic send_triangle(input logic [REQ_W-1:0] tri_bits);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tri_bits;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_xy(input int x1, y1, x2, y2, x3, y3);
      send_triangle({y3[15:0], x3[15:0], y2[15:0], x2[15:0], y1[15:0], x1[15:0]});
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Random triangle: most often full-range words, some small coordinates around
   // a random origin, some nearly collinear and some exactly collinear.
   function automatic logic [REQ_W-1:0] random_triangle();
      logic [REQ_W-1:0] t;
      int ox, oy, dx, dy, k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            t = {$urandom, $urandom, $urandom};
         end
         4, 5, 6: begin
            ox = $urandom_range(0, 65535) - 32768;
            oy = $urandom_range(0, 65535) - 32768;
            for (int i = 0; i < 3; i++) begin
               dx = ox + $urandom_range(0, 1023) - 512;
               dy = oy + $urandom_range(0, 1023) - 512;
               t[32*i +: 16] = dx[15:0];
               t[32*i+16 +: 16] = dy[15:0];
            end
         end
         default: begin
            ox = $urandom_range(0, 2047) - 1024;
            oy = $urandom_range(0, 2047) - 1024;
            dx = $urandom_range(0, 200) - 100;
            dy = $urandom_range(0, 200) - 100;
            k  = $urandom_range(0, 10) - 5;
            t = {16'(oy + k * dy + $urandom_range(0, 1)), 16'(ox + k * dx),
                 16'(oy + dy), 16'(ox + dx), 16'(oy), 16'(ox)};
         end
      endcase
      return t;
   endfunction

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, coincident and collinear points, tiny and huge
      // triangles, and centres far enough out to saturate.
      send_xy(0, 0, 0, 0, 0, 0);
      send_xy(-32768, -32768, -32768, -32768, -32768, -32768);
      send_xy(0, 0, 256, 256, 512, 512);
      send_xy(-32768, -32768, 0, 0, 32767, 32767);
      send_xy(0, 0, 256, 0, 0, 256);
      send_xy(0, 0, 0, 256, 256, 0);
      send_xy(0, 0, 1, 0, 0, 1);
      send_xy(-32768, -32768, 32767, -32768, -32768, 32767);
      send_xy(32767, 32767, -32768, 32767, 32767, -32768);
      send_xy(-32768, 0, 32767, 0, 0, 32767);
      send_xy(-32768, -32768, 32767, 32767, 32767, 32766);
      send_xy(-32768, -32768, 32767, 32767, 32766, 32767);
      send_xy(0, 0, 1, 1, 2, 1);
      send_xy(-32768, 32767, 32767, -32768, 32767, -32767);
      send_xy(100, 100, 101, 100, 100, 101);
      send_xy(-1, -1, 1, 1, -1, 1);
      send_xy(32767, 0, -32768, 1, 0, -32768);
      send_xy(5, -7, 5, -7, 9, 3);

      // The sender pauses until every expected result has come.
      wait_drained();

      // Long receiver hold-off while the sender keeps offering items.
      long_hold = 1'b1;
      for (int i = 0; i < 200; i++) send_triangle(random_triangle());

      for (int i = 0; i < N_RANDOM; i++) send_triangle(random_triangle());

      wait_drained();
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && board.pending.size() == 0) begin
         $display("triangle_circumcircle test passed");
      end else begin
         $display("triangle_circumcircle test failed");
      end
      $finish;
   end

endmodule
